// ----- sv/bemf_zct_pkg.sv -----
package bemf_zct_pkg;

    localparam int CAPTURE_W = 16;
    localparam int PIN_W     = 12;
    localparam int MATCH_W   = 17;
    localparam int WORD_W    = 32;
    localparam int WEIGHT_W  = 8;
    localparam int ADDR_W    = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_CORRECTION = 2'd0;
    localparam logic [1:0] REG_NEW_WEIGHT = 2'd1;
    localparam logic [1:0] REG_OLD_WEIGHT = 2'd2;

    localparam logic [CAPTURE_W-1:0] CORRECTION_RESET = '0;
    localparam logic [WEIGHT_W-1:0]  NEW_WEIGHT_RESET = 8'd1;
    localparam logic [WEIGHT_W-1:0]  OLD_WEIGHT_RESET = 8'd7;

    typedef struct packed {
        logic [PIN_W-1:0]     pin_status;
        logic [PIN_W-1:0]     expected_pin_mask;
        logic [CAPTURE_W-1:0] capture_time;
        logic [CAPTURE_W-1:0] commutation_period;
    } in_item_t;

    typedef struct packed {
        logic [MATCH_W-1:0] next_match_time;
        logic [WORD_W-1:0]  filtered_time;
        logic [WORD_W-1:0]  crossing_count;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ----- sv/bemf_zero_crossing_commutation_timer.sv -----
// Sensorless BLDC zero-crossing commutation timer. Each request on the input
// channel is one pin-change event; it produces a result only when pin_status
// and expected_pin_mask share a bit, and is otherwise dropped. A matching
// event is then worked on in order: a shift-and-add multiplier that forms
// A*(capture-correction) + B*filtered one weight bit per cycle, a restoring
// divider by A+B that yields one quotient bit per cycle, and a load of the
// output register. The input is stalled while that work runs, and for longer
// when the previous result is still held in the output register by out_stall
// at the moment the new one is ready. A finished result may wait in the
// output register while the next event is already being taken. When both
// weights are zero the filtered value is kept. Configuration registers sit
// at byte addresses 0 (crossing_correction), 4 (new_sample_weight) and 8
// (old_value_weight) and should be written only while the block is idle.
module bemf_zero_crossing_commutation_timer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bemf_zct_pkg::in_item_t        in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bemf_zct_pkg::out_item_t       out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bemf_zct_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bemf_zct_pkg::*;

    state_t state_reg, state_next;

    logic [CAPTURE_W-1:0] corr_reg;
    logic [WEIGHT_W-1:0]  wnew_reg;
    logic [WEIGHT_W-1:0]  wold_reg;

    logic [WORD_W-1:0] filt_reg, filt_next;
    logic [WORD_W-1:0] count_reg, count_next;

    logic [WORD_W-1:0]   work_reg, work_next;
    logic [WORD_W-1:0]   corr_sh_reg, corr_sh_next;
    logic [WORD_W-1:0]   filt_sh_reg, filt_sh_next;
    logic [WEIGHT_W-1:0] wa_sh_reg, wa_sh_next;
    logic [WEIGHT_W-1:0] wb_sh_reg, wb_sh_next;
    logic [WEIGHT_W:0]   rem_reg, rem_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [MATCH_W-1:0]  match_reg, match_next;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic                 accept;
    logic                 hit;
    logic [CAPTURE_W-1:0] half;
    logic [WEIGHT_W:0]    denom;
    logic [WEIGHT_W+1:0]  trial;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_reg <= CORRECTION_RESET;
            wnew_reg <= NEW_WEIGHT_RESET;
            wold_reg <= OLD_WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_CORRECTION: corr_reg <= pwdata[CAPTURE_W-1:0];
                REG_NEW_WEIGHT: wnew_reg <= pwdata[WEIGHT_W-1:0];
                REG_OLD_WEIGHT: wold_reg <= pwdata[WEIGHT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CORRECTION: prdata = {16'h0, corr_reg};
            REG_NEW_WEIGHT: prdata = {24'h0, wnew_reg};
            REG_OLD_WEIGHT: prdata = {24'h0, wold_reg};
            default:        prdata = '0;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign hit       = |(in_data.pin_status & in_data.expected_pin_mask);
    assign half      = in_data.commutation_period >> 1;
    assign denom     = {1'b0, wnew_reg} + {1'b0, wold_reg};
    assign trial     = {rem_reg, work_reg[WORD_W-1]};
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filt_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            filt_reg      <= filt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        corr_sh_reg  <= corr_sh_next;
        filt_sh_reg  <= filt_sh_next;
        wa_sh_reg    <= wa_sh_next;
        wb_sh_reg    <= wb_sh_next;
        rem_reg      <= rem_next;
        match_reg    <= match_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        filt_next      = filt_reg;
        count_next     = count_reg;
        work_next      = work_reg;
        corr_sh_next   = corr_sh_reg;
        filt_sh_next   = filt_sh_reg;
        wa_sh_next     = wa_sh_reg;
        wb_sh_next     = wb_sh_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        match_next     = match_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && hit)
                begin
                    // The capture is widened before the subtraction so that a
                    // capture below the correction wraps over the full word.
                    corr_sh_next = {16'h0, in_data.capture_time} - {16'h0, corr_reg};
                    filt_sh_next = filt_reg;
                    wa_sh_next   = wnew_reg;
                    wb_sh_next   = wold_reg;
                    work_next    = '0;
                    cnt_next     = '0;
                    match_next   = {1'b0, half} + {1'b0, in_data.capture_time};
                    if (in_data.capture_time >= half)
                    begin
                        count_next = count_reg + 32'd1;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                work_next = work_reg
                          + (wa_sh_reg[0] ? corr_sh_reg : '0)
                          + (wb_sh_reg[0] ? filt_sh_reg : '0);
                corr_sh_next = corr_sh_reg << 1;
                filt_sh_next = filt_sh_reg << 1;
                wa_sh_next   = wa_sh_reg >> 1;
                wb_sh_next   = wb_sh_reg >> 1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // The dividend shifts out of the top of work_reg while the
                // quotient bits shift in at the bottom.
                if (trial >= {1'b0, denom})
                begin
                    rem_next  = (WEIGHT_W+1)'(trial - {1'b0, denom});
                    work_next = {work_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[WEIGHT_W:0];
                    work_next = {work_reg[WORD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    if (denom != '0)
                    begin
                        filt_next = work_next;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.next_match_time = match_reg;
                    out_data_next.filtered_time   = filt_reg;
                    out_data_next.crossing_count  = count_reg;
                    out_valid_next                = 1'b1;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
